// ----- design/pnp_pkg.sv -----
// shared constants, types and helpers of the polyline nearest point block
`default_nettype none

package pnp_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int FRAC_BITS    = 16;
   localparam int PROJ_BITS    = 30;

   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int CNT_W  = ($clog2(MAX_VERTICES + 1) > 9) ? $clog2(MAX_VERTICES + 1) : 9;

   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;

   localparam int DIV_NUM_W = 32 + FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [62:0] DIST_MAX = '1;

   localparam logic [1:0] FUNC_WRITE  = 2'd0;
   localparam logic [1:0] FUNC_SEARCH = 2'd1;
   localparam logic [1:0] FUNC_HINT   = 2'd2;
   localparam logic [1:0] FUNC_DIR    = 2'd3;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // one classified item on its way from the front to the back
   typedef struct packed {
      logic               err;
      logic [1:0]         func;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic [ADDR_W-1:0]  seg;
      logic [ADDR_W-1:0]  last_seg;
   } pnp_cmd_type;

   // divide by four, truncating toward zero
   function automatic logic signed [MUL_W-1:0] quarter(input logic signed [MUL_W-1:0] v);
      logic signed [MUL_W-1:0] adj;
      adj = v + $signed({{(MUL_W-2){1'b0}}, v[MUL_W-1], v[MUL_W-1]});
      return adj >>> 2;
   endfunction

endpackage

`default_nettype wire

// ----- design/pnp_if.sv -----
// request and response channel interfaces
`default_nettype none

interface pnp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic [7:0]         index;

   modport source(output valid, func, point_x, point_y, index, input ready);
   modport sink(input valid, func, point_x, point_y, index, output ready);
endinterface

interface pnp_rsp_if;
   logic               valid;
   logic               ready;
   logic               status;
   logic [7:0]         segment;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic [62:0]        dist_sq;

   modport source(output valid, status, segment, out_x, out_y, dist_sq, input ready);
   modport sink(input valid, status, segment, out_x, out_y, dist_sq, output ready);
endinterface

`default_nettype wire

// ----- design/polyline_nearest_point_core.sv -----
// top level of the polyline nearest point block
// usage:
//  - req_ch carries items (func, point_x, point_y, index) under valid/ready;
//    rsp_ch returns one result item per request item, in request order
//  - csr_write_en/csr_write_data load vertex_count; the user must write it
//    only while the block is idle, which the block itself does not enforce
//  - a vertex write or a rejected item goes from idle straight to done; a
//    segment whose point clamps to an end skips the 30-step restoring divider
//  - all products share the single multiplier; full search visits every
//    segment, hinted mapping up to three segments, direction a normalise
//    shift, 32-step square root and two 48-step divisions unless zero-length
//  - one item is worked on at a time; the front and a two-deep queue keep
//    taking items while the back is busy or a result waits
//  - a finished result sits in an output register, so a stalled receiver
//    only holds the back once the next item is ready to report
//  - reset empties queue and output register and sets vertex_count to 2;
//    vertex contents are undefined until written
`default_nettype none

module polyline_nearest_point_core import pnp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pnp_req_if.sink    req_ch,
   pnp_rsp_if.source  rsp_ch,
   input  logic       csr_write_en,
   input  logic [8:0] csr_write_data
);

   logic [8:0]  vertex_count_ff, vertex_count_in;

   // front to queue
   logic        push_valid, push_ready;
   pnp_cmd_type push_cmd;

   // queue to back
   logic        pop_valid, pop_ready;
   pnp_cmd_type pop_cmd;

   // vertex count register
   assign vertex_count_in = csr_write_en ? csr_write_data : vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= 9'd2;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   // classify and range check items
   pnp_front u_front (
      .req          (req_ch),
      .vertex_count (vertex_count_ff),
      .push_ready   (push_ready),
      .push_valid   (push_valid),
      .push_cmd     (push_cmd)
   );

   // decoupling queue
   pnp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_cmd)
   );

   // projection and direction engine with the vertex store
   pnp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_cmd),
      .rsp       (rsp_ch)
   );

   // an error result carries nothing but its status
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == STATUS_ERR)) |->
      ((rsp_ch.segment == 8'd0) && (rsp_ch.out_x == 32'sd0) &&
       (rsp_ch.out_y == 32'sd0) && (rsp_ch.dist_sq == 63'd0)))
      else $error("error result with non-zero payload");

   // a good result names a segment that exists
   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == STATUS_OK)) |->
      ((rsp_ch.segment == 8'd0) || ({1'b0, rsp_ch.segment} < vertex_count_ff)))
      else $error("result segment beyond vertex count");

endmodule

`default_nettype wire

// ----- design/pnp_front.sv -----
// front end: takes items and checks them against the vertex count
`default_nettype none

module pnp_front import pnp_pkg::*; (
   pnp_req_if.sink           req,
   input  logic [8:0]        vertex_count,
   input  logic              push_ready,
   output logic              push_valid,
   output pnp_cmd_type       push_cmd
);

   logic [CNT_W-1:0] n_used;
   logic [CNT_W-1:0] segs;
   logic [CNT_W-1:0] idx_w;
   logic             err;

   assign n_used = (CNT_W'(vertex_count) < CNT_W'(MAX_VERTICES)) ?
                   CNT_W'(vertex_count) : CNT_W'(MAX_VERTICES);
   assign segs   = (n_used >= CNT_W'(2)) ? n_used - CNT_W'(1) : '0;
   assign idx_w  = CNT_W'(req.index);

   always_comb begin
      if (req.func == FUNC_WRITE) begin
         err = (idx_w >= CNT_W'(MAX_VERTICES));
      end else begin
         err = (segs == '0) || ((req.func != FUNC_SEARCH) && (idx_w >= segs));
      end
   end

   assign push_cmd.err      = err;
   assign push_cmd.func     = req.func;
   assign push_cmd.point_x  = req.point_x;
   assign push_cmd.point_y  = req.point_y;
   assign push_cmd.seg      = ADDR_W'(req.index);
   assign push_cmd.last_seg = ADDR_W'(segs - CNT_W'(1));

   assign push_valid = req.valid;
   assign req.ready  = push_ready;

endmodule

`default_nettype wire

// ----- design/pnp_fifo.sv -----
// short command queue between front and back
`default_nettype none

module pnp_fifo import pnp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  pnp_cmd_type push_data,
   output logic        pop_valid,
   input  logic        pop_ready,
   output pnp_cmd_type pop_data
);

   pnp_cmd_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign push_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- design/pnp_back.sv -----
// back end: vertex store, projection, distance and direction sequencer
`default_nettype none

module pnp_back import pnp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  pnp_cmd_type pop_data,
   pnp_rsp_if.source   rsp
);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_RDA   = 5'd1;
   localparam logic [4:0] ST_RDB   = 5'd2;
   localparam logic [4:0] ST_CALC  = 5'd3;
   localparam logic [4:0] ST_M1    = 5'd4;
   localparam logic [4:0] ST_M2    = 5'd5;
   localparam logic [4:0] ST_M3    = 5'd6;
   localparam logic [4:0] ST_M4    = 5'd7;
   localparam logic [4:0] ST_M5    = 5'd8;
   localparam logic [4:0] ST_CLAMP = 5'd9;
   localparam logic [4:0] ST_DIV   = 5'd10;
   localparam logic [4:0] ST_I1    = 5'd11;
   localparam logic [4:0] ST_I2    = 5'd12;
   localparam logic [4:0] ST_I3    = 5'd13;
   localparam logic [4:0] ST_D1    = 5'd14;
   localparam logic [4:0] ST_D2    = 5'd15;
   localparam logic [4:0] ST_D3    = 5'd16;
   localparam logic [4:0] ST_DN    = 5'd17;
   localparam logic [4:0] ST_DM1   = 5'd18;
   localparam logic [4:0] ST_DM2   = 5'd19;
   localparam logic [4:0] ST_DM3   = 5'd20;
   localparam logic [4:0] ST_SQRT  = 5'd21;
   localparam logic [4:0] ST_DQX   = 5'd22;
   localparam logic [4:0] ST_DQY   = 5'd23;
   localparam logic [4:0] ST_DEND  = 5'd24;
   localparam logic [4:0] ST_DONE  = 5'd25;

   typedef struct packed {
      pnp_cmd_type              cmd;
      logic [ADDR_W-1:0]        seg;
      logic [1:0]               phase;
      logic                     first;
      logic signed [31:0]       ax;
      logic signed [31:0]       ay;
      logic signed [31:0]       bx;
      logic signed [31:0]       by;
      logic signed [MUL_W-1:0]  abx;
      logic signed [MUL_W-1:0]  aby;
      logic signed [MUL_W-1:0]  rabx;
      logic signed [MUL_W-1:0]  raby;
      logic signed [MUL_W-1:0]  rapx;
      logic signed [MUL_W-1:0]  rapy;
      logic signed [PROD_W-1:0] len2;
      logic signed [PROD_W-1:0] dot;
      logic [32:0]              ux;
      logic [32:0]              uy;
      logic [32:0]              um;
      logic [63:0]              rem;
      logic [63:0]              den;
      logic [DIV_NUM_W-1:0]     num;
      logic [DIV_NUM_W-1:0]     quo;
      logic [DIV_CNT_W-1:0]     dcnt;
      logic [4:0]               div_ret;
      logic [63:0]              sq_n;
      logic [63:0]              sq_res;
      logic [63:0]              sq_bit;
      logic [DIV_NUM_W-1:0]     qx;
      logic signed [MUL_W-1:0]  cx;
      logic signed [MUL_W-1:0]  cy;
      logic [PROD_W-1:0]        asq;
      logic                     status;
      logic [ADDR_W-1:0]        best_seg;
      logic [31:0]              best_x;
      logic [31:0]              best_y;
      logic [62:0]              best_d;
   } pnp_dp_type;

   logic [4:0]               state_ff, state_in;
   pnp_dp_type               dp_ff, dp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     load_rsp;

   logic [63:0]              vert_mem [MAX_VERTICES];
   logic [63:0]              rd_data_ff;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     mem_we;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p_ff, mul_p_in;

   logic                     out_status_ff;
   logic [7:0]               out_seg_ff;
   logic [31:0]              out_x_ff, out_y_ff;
   logic [62:0]              out_d_ff;

   logic signed [31:0]       rd_x, rd_y;
   logic signed [MUL_W-1:0]  abx_c, aby_c, apx_c, apy_c;
   logic [32:0]              ux_c, uy_c;
   logic [63:0]              rem2_c;
   logic                     ge_c;
   logic [63:0]              trial_c;
   logic [PROD_W-1:0]        rnd_c;
   logic signed [MUL_W-1:0]  off_c, ix_c, iy_c;
   logic signed [MUL_W-1:0]  dx_c, dy_c;
   logic [PROD_W:0]          dsum_c;
   logic [62:0]              td_c;
   logic signed [MUL_W-1:0]  mag_abx, mag_aby;
   logic [31:0]              qx32, qy32;

   assign rd_x  = $signed(rd_data_ff[31:0]);
   assign rd_y  = $signed(rd_data_ff[63:32]);
   assign abx_c = MUL_W'(rd_x) - MUL_W'(dp_ff.ax);
   assign aby_c = MUL_W'(rd_y) - MUL_W'(dp_ff.ay);
   assign apx_c = MUL_W'(dp_ff.cmd.point_x) - MUL_W'(dp_ff.ax);
   assign apy_c = MUL_W'(dp_ff.cmd.point_y) - MUL_W'(dp_ff.ay);
   assign ux_c  = abx_c[MUL_W-1] ? 33'(-abx_c) : 33'(abx_c);
   assign uy_c  = aby_c[MUL_W-1] ? 33'(-aby_c) : 33'(aby_c);

   assign mag_abx = dp_ff.abx[MUL_W-1] ? -dp_ff.abx : dp_ff.abx;
   assign mag_aby = dp_ff.aby[MUL_W-1] ? -dp_ff.aby : dp_ff.aby;

   // restoring divider step
   assign rem2_c = {dp_ff.rem[62:0], dp_ff.num[DIV_NUM_W-1]};
   assign ge_c   = (rem2_c >= dp_ff.den);

   assign trial_c = dp_ff.sq_res + dp_ff.sq_bit;

   // rounded interpolation offset from the registered product
   assign rnd_c = $unsigned(mul_p_ff) + (PROD_W'(1) << (PROJ_BITS - 1));
   assign off_c = $signed(MUL_W'(rnd_c >> PROJ_BITS));
   assign ix_c  = dp_ff.abx[MUL_W-1] ? MUL_W'(dp_ff.ax) - off_c : MUL_W'(dp_ff.ax) + off_c;
   assign iy_c  = dp_ff.aby[MUL_W-1] ? MUL_W'(dp_ff.ay) - off_c : MUL_W'(dp_ff.ay) + off_c;

   assign dx_c   = MUL_W'(dp_ff.cmd.point_x) - dp_ff.cx;
   assign dy_c   = MUL_W'(dp_ff.cmd.point_y) - dp_ff.cy;
   assign dsum_c = {1'b0, dp_ff.asq} + {1'b0, $unsigned(mul_p_ff)};
   assign td_c   = (dsum_c > (PROD_W + 1)'(DIST_MAX)) ? DIST_MAX : dsum_c[62:0];

   assign qx32 = 32'(dp_ff.qx);
   assign qy32 = 32'(dp_ff.quo);

   assign mul_p_in = mul_a * mul_b;

   always_comb begin
      dp_in     = dp_ff;
      state_in  = state_ff;
      pop_ready = 1'b0;
      mem_we    = 1'b0;
      rd_addr   = dp_ff.seg;
      mul_a     = '0;
      mul_b     = '0;
      load_rsp  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               pop_ready       = 1'b1;
               dp_in.cmd       = pop_data;
               dp_in.status    = pop_data.err ? STATUS_ERR : STATUS_OK;
               dp_in.best_seg  = '0;
               dp_in.best_x    = '0;
               dp_in.best_y    = '0;
               dp_in.best_d    = '0;
               dp_in.first     = 1'b1;
               dp_in.phase     = 2'd0;
               dp_in.seg       = (pop_data.func == FUNC_SEARCH) ? '0 : pop_data.seg;
               if (pop_data.err) begin
                  state_in = ST_DONE;
               end else if (pop_data.func == FUNC_WRITE) begin
                  mem_we   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RDA;
               end
            end
         end
         ST_RDA: begin
            state_in = ST_RDB;
         end
         ST_RDB: begin
            rd_addr  = dp_ff.seg + ADDR_W'(1);
            dp_in.ax = rd_x;
            dp_in.ay = rd_y;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            dp_in.bx   = rd_x;
            dp_in.by   = rd_y;
            dp_in.abx  = abx_c;
            dp_in.aby  = aby_c;
            dp_in.rabx = quarter(abx_c);
            dp_in.raby = quarter(aby_c);
            dp_in.rapx = quarter(apx_c);
            dp_in.rapy = quarter(apy_c);
            dp_in.ux   = ux_c;
            dp_in.uy   = uy_c;
            dp_in.um   = (ux_c > uy_c) ? ux_c : uy_c;
            if (dp_ff.cmd.func == FUNC_DIR) begin
               if ((ux_c == '0) && (uy_c == '0)) begin
                  dp_in.best_seg = dp_ff.cmd.seg;
                  state_in       = ST_DONE;
               end else begin
                  state_in = ST_DN;
               end
            end else begin
               state_in = ST_M1;
            end
         end
         ST_M1: begin
            mul_a    = dp_ff.rabx;
            mul_b    = dp_ff.rabx;
            state_in = ST_M2;
         end
         ST_M2: begin
            dp_in.len2 = mul_p_ff;
            mul_a      = dp_ff.raby;
            mul_b      = dp_ff.raby;
            state_in   = ST_M3;
         end
         ST_M3: begin
            dp_in.len2 = dp_ff.len2 + mul_p_ff;
            mul_a      = dp_ff.rapx;
            mul_b      = dp_ff.rabx;
            state_in   = ST_M4;
         end
         ST_M4: begin
            dp_in.dot = mul_p_ff;
            mul_a     = dp_ff.rapy;
            mul_b     = dp_ff.raby;
            state_in  = ST_M5;
         end
         ST_M5: begin
            dp_in.dot = dp_ff.dot + mul_p_ff;
            state_in  = ST_CLAMP;
         end
         ST_CLAMP: begin
            // zero length or behind end A maps to A, past end B maps to B
            if ((dp_ff.len2 == '0) || dp_ff.dot[PROD_W-1] || (dp_ff.dot == '0)) begin
               dp_in.cx = MUL_W'(dp_ff.ax);
               dp_in.cy = MUL_W'(dp_ff.ay);
               state_in = ST_D1;
            end else if (dp_ff.dot >= dp_ff.len2) begin
               dp_in.cx = MUL_W'(dp_ff.bx);
               dp_in.cy = MUL_W'(dp_ff.by);
               state_in = ST_D1;
            end else begin
               dp_in.rem     = 64'(dp_ff.dot);
               dp_in.den     = 64'(dp_ff.len2);
               dp_in.num     = '0;
               dp_in.quo     = '0;
               dp_in.dcnt    = DIV_CNT_W'(PROJ_BITS);
               dp_in.div_ret = ST_I1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            dp_in.rem  = ge_c ? rem2_c - dp_ff.den : rem2_c;
            dp_in.quo  = {dp_ff.quo[DIV_NUM_W-2:0], ge_c};
            dp_in.num  = {dp_ff.num[DIV_NUM_W-2:0], 1'b0};
            dp_in.dcnt = dp_ff.dcnt - DIV_CNT_W'(1);
            if (dp_ff.dcnt == DIV_CNT_W'(1)) begin
               state_in = dp_ff.div_ret;
            end
         end
         ST_I1: begin
            mul_a    = mag_abx;
            mul_b    = $signed(MUL_W'(dp_ff.quo[PROJ_BITS-1:0]));
            state_in = ST_I2;
         end
         ST_I2: begin
            dp_in.cx = ix_c;
            mul_a    = mag_aby;
            mul_b    = $signed(MUL_W'(dp_ff.quo[PROJ_BITS-1:0]));
            state_in = ST_I3;
         end
         ST_I3: begin
            dp_in.cy = iy_c;
            state_in = ST_D1;
         end
         ST_D1: begin
            mul_a    = dx_c;
            mul_b    = dx_c;
            state_in = ST_D2;
         end
         ST_D2: begin
            dp_in.asq = $unsigned(mul_p_ff);
            mul_a     = dy_c;
            mul_b     = dy_c;
            state_in  = ST_D3;
         end
         ST_D3: begin
            dp_in.first = 1'b0;
            if (dp_ff.first || (td_c < dp_ff.best_d)) begin
               dp_in.best_d   = td_c;
               dp_in.best_seg = dp_ff.seg;
               dp_in.best_x   = 32'(dp_ff.cx);
               dp_in.best_y   = 32'(dp_ff.cy);
            end
            state_in = ST_DONE;
            if (dp_ff.cmd.func == FUNC_SEARCH) begin
               if (dp_ff.seg != dp_ff.cmd.last_seg) begin
                  dp_in.seg = dp_ff.seg + ADDR_W'(1);
                  state_in  = ST_RDA;
               end
            end else begin
               // hint first, then previous, then next neighbour
               priority if ((dp_ff.phase == 2'd0) && (dp_ff.cmd.seg != '0)) begin
                  dp_in.seg   = dp_ff.cmd.seg - ADDR_W'(1);
                  dp_in.phase = 2'd1;
                  state_in    = ST_RDA;
               end else if ((dp_ff.phase != 2'd2) && (dp_ff.cmd.seg != dp_ff.cmd.last_seg)) begin
                  dp_in.seg   = dp_ff.cmd.seg + ADDR_W'(1);
                  dp_in.phase = 2'd2;
                  state_in    = ST_RDA;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DN: begin
            if (dp_ff.um[32:31] != 2'b00) begin
               dp_in.ux = dp_ff.ux >> 1;
               dp_in.uy = dp_ff.uy >> 1;
               dp_in.um = dp_ff.um >> 1;
            end else if (!dp_ff.um[30]) begin
               dp_in.ux = dp_ff.ux << 1;
               dp_in.uy = dp_ff.uy << 1;
               dp_in.um = dp_ff.um << 1;
            end else begin
               state_in = ST_DM1;
            end
         end
         ST_DM1: begin
            mul_a    = $signed(MUL_W'(dp_ff.ux));
            mul_b    = $signed(MUL_W'(dp_ff.ux));
            state_in = ST_DM2;
         end
         ST_DM2: begin
            dp_in.sq_n = 64'(mul_p_ff);
            mul_a      = $signed(MUL_W'(dp_ff.uy));
            mul_b      = $signed(MUL_W'(dp_ff.uy));
            state_in   = ST_DM3;
         end
         ST_DM3: begin
            dp_in.sq_n   = dp_ff.sq_n + 64'(mul_p_ff);
            dp_in.sq_res = '0;
            dp_in.sq_bit = 64'(1) << 62;
            state_in     = ST_SQRT;
         end
         ST_SQRT: begin
            if (dp_ff.sq_n >= trial_c) begin
               dp_in.sq_n   = dp_ff.sq_n - trial_c;
               dp_in.sq_res = (dp_ff.sq_res >> 1) + dp_ff.sq_bit;
            end else begin
               dp_in.sq_res = dp_ff.sq_res >> 1;
            end
            dp_in.sq_bit = dp_ff.sq_bit >> 2;
            if (dp_ff.sq_bit == 64'd1) begin
               state_in = ST_DQX;
            end
         end
         ST_DQX: begin
            dp_in.rem     = '0;
            dp_in.den     = dp_ff.sq_res;
            dp_in.num     = DIV_NUM_W'({dp_ff.ux, {FRAC_BITS{1'b0}}})
                            + DIV_NUM_W'(dp_ff.sq_res >> 1);
            dp_in.quo     = '0;
            dp_in.dcnt    = DIV_CNT_W'(DIV_NUM_W);
            dp_in.div_ret = ST_DQY;
            state_in      = ST_DIV;
         end
         ST_DQY: begin
            dp_in.qx      = dp_ff.quo;
            dp_in.rem     = '0;
            dp_in.num     = DIV_NUM_W'({dp_ff.uy, {FRAC_BITS{1'b0}}})
                            + DIV_NUM_W'(dp_ff.sq_res >> 1);
            dp_in.quo     = '0;
            dp_in.dcnt    = DIV_CNT_W'(DIV_NUM_W);
            dp_in.div_ret = ST_DEND;
            state_in      = ST_DIV;
         end
         ST_DEND: begin
            dp_in.best_x   = dp_ff.abx[MUL_W-1] ? -qx32 : qx32;
            dp_in.best_y   = dp_ff.aby[MUL_W-1] ? -qy32 : qy32;
            dp_in.best_d   = '0;
            dp_in.best_seg = dp_ff.cmd.seg;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dp_ff    <= dp_in;
      mul_p_ff <= mul_p_in;
      if (load_rsp) begin
         out_status_ff <= dp_ff.status;
         out_seg_ff    <= 8'(dp_ff.best_seg);
         out_x_ff      <= dp_ff.best_x;
         out_y_ff      <= dp_ff.best_y;
         out_d_ff      <= dp_ff.best_d;
      end
   end

   // vertex store, x in the low half and y in the high half
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vert_mem[pop_data.seg] <= {pop_data.point_y, pop_data.point_x};
      end
      rd_data_ff <= vert_mem[rd_addr];
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.status  = out_status_ff;
   assign rsp.segment = out_seg_ff;
   assign rsp.out_x   = $signed(out_x_ff);
   assign rsp.out_y   = $signed(out_y_ff);
   assign rsp.dist_sq = out_d_ff;

endmodule

`default_nettype wire
